FILE: design/seed_delta_rtc_calendar_stepper_assert.svh
// assertion macros shared by the rtl files
`ifndef SEED_DELTA_RTC_CALENDAR_STEPPER_ASSERT_SVH
`define SEED_DELTA_RTC_CALENDAR_STEPPER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define SDRTC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SDRTC_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDRTC_ASSERT(label, clk, rst, prop, msg)
`define SDRTC_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

FILE: design/sdrtc_pkg.sv
package sdrtc_pkg;

   localparam logic [31:0] STEP_UNIT = 32'd1000;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cal_time_type;

   typedef struct packed {
      logic load;
      logic clamp;
      logic step;
      logic fwd;
   } cal_ctrl_type;

   // y / 100 through a reciprocal, exact for 12-bit years
   function automatic logic is_leap(input logic [11:0] y);
      logic [24:0] prod;
      logic [5:0]  q;
      logic [12:0] back;
      logic        div100;
      prod   = {13'd0, y} * 25'd5243;
      q      = prod[24:19];
      back   = {7'd0, q} * 13'd100;
      div100 = (back == {1'b0, y});
      return (y[1:0] == 2'b00) && (!div100 || (q[1:0] == 2'b00));
   endfunction

   function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
      logic [4:0] d;
      case (month)
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         4'd2:                    d = leap ? 5'd29 : 5'd28;
         default:                 d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

FILE: design/sdrtc_calendar.sv
`include "seed_delta_rtc_calendar_stepper_assert.svh"

module sdrtc_calendar (
   input  logic                  clock,
   input  logic                  reset,
   input  sdrtc_pkg::cal_ctrl_type ctrl,
   input  sdrtc_pkg::cal_time_type start,
   output sdrtc_pkg::cal_time_type now
);
   import sdrtc_pkg::*;

   cal_time_type cal_ff, cal_in;
   logic         leap_ff, leap_in;

   // leap flag is a registered copy of the year's leap test and trails the year; a year change lands on jan 1 or
   // dec 31, so the flag is settled long before february is reached
   assign leap_in = is_leap(cal_ff.year);

   always_comb begin
      logic [4:0] dim;
      logic [4:0] dim_prev;
      cal_in   = cal_ff;
      dim      = days_in(cal_ff.month, leap_ff);
      dim_prev = days_in(cal_ff.month - 4'd1, leap_ff);
      if (ctrl.load) begin
         cal_in.year   = start.year;
         cal_in.month  = (start.month == 4'd0) ? 4'd1 :
                         (start.month > 4'd12) ? 4'd12 : start.month;
         cal_in.day    = (start.day == 5'd0) ? 5'd1 : start.day;
         cal_in.hour   = (start.hour > 5'd23) ? 5'd23 : start.hour;
         cal_in.minute = (start.minute > 6'd59) ? 6'd59 : start.minute;
         cal_in.second = (start.second > 6'd59) ? 6'd59 : start.second;
      end else if (ctrl.clamp) begin
         if (cal_ff.day > dim) begin
            cal_in.day = dim;
         end
      end else if (ctrl.step && ctrl.fwd) begin
         if (cal_ff.second == 6'd59) begin
            cal_in.second = 6'd0;
            if (cal_ff.minute == 6'd59) begin
               cal_in.minute = 6'd0;
               if (cal_ff.hour == 5'd23) begin
                  cal_in.hour = 5'd0;
                  if (cal_ff.day >= dim) begin
                     cal_in.day = 5'd1;
                     if (cal_ff.month >= 4'd12) begin
                        cal_in.month = 4'd1;
                        cal_in.year  = cal_ff.year + 12'd1;
                     end else begin
                        cal_in.month = cal_ff.month + 4'd1;
                     end
                  end else begin
                     cal_in.day = cal_ff.day + 5'd1;
                  end
               end else begin
                  cal_in.hour = cal_ff.hour + 5'd1;
               end
            end else begin
               cal_in.minute = cal_ff.minute + 6'd1;
            end
         end else begin
            cal_in.second = cal_ff.second + 6'd1;
         end
      end else if (ctrl.step) begin
         if (cal_ff.second == 6'd0) begin
            cal_in.second = 6'd59;
            if (cal_ff.minute == 6'd0) begin
               cal_in.minute = 6'd59;
               if (cal_ff.hour == 5'd0) begin
                  cal_in.hour = 5'd23;
                  if (cal_ff.day <= 5'd1) begin
                     if (cal_ff.month <= 4'd1) begin
                        cal_in.month = 4'd12;
                        cal_in.day   = 5'd31;
                        cal_in.year  = cal_ff.year - 12'd1;
                     end else begin
                        cal_in.month = cal_ff.month - 4'd1;
                        cal_in.day   = dim_prev;
                     end
                  end else begin
                     cal_in.day = cal_ff.day - 5'd1;
                  end
               end else begin
                  cal_in.hour = cal_ff.hour - 5'd1;
               end
            end else begin
               cal_in.minute = cal_ff.minute - 6'd1;
            end
         end else begin
            cal_in.second = cal_ff.second - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff  <= '0;
         leap_ff <= 1'b0;
      end else begin
         cal_ff  <= cal_in;
         leap_ff <= leap_in;
      end
   end

   assign now = cal_ff;

   `SDRTC_ASSERT(a_time_range, clock, reset, (cal_ff.hour <= 5'd23 && cal_ff.minute <= 6'd59 && cal_ff.second <= 6'd59), "calendar time field out of range")
   `SDRTC_ASSERT(a_date_on_step, clock, reset, ctrl.step |-> (cal_ff.month >= 4'd1 && cal_ff.month <= 4'd12 && cal_ff.day >= 5'd1), "calendar stepped from an invalid date")
   `SDRTC_ASSERT(a_day_clamped, clock, reset, ctrl.clamp |=> (cal_ff.day <= days_in(cal_ff.month, leap_ff)), "day not clamped to month length")

endmodule

FILE: design/seed_delta_rtc_calendar_stepper.sv
// the calendar steps n = |target - new| / 1000 seconds per item (up to 4294967)
// a new item is taken only once the last result is emitted; the calendar unit moves one second per cycle
// the step count is set by a subtract-1000 loop on the remaining distance
// a finished result waits in an output register while the next item is taken
// reset: synchronous, active high; clears control, calendar and elapsed counters
`include "seed_delta_rtc_calendar_stepper_assert.svh"

module seed_delta_rtc_calendar_stepper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_initial_seed,
   input  logic [31:0] req_save_param,
   input  logic [31:0] req_new_save_param,
   input  logic [31:0] req_target_seed,
   input  logic [11:0] req_start_year,
   input  logic [3:0]  req_start_month,
   input  logic [4:0]  req_start_day,
   input  logic [4:0]  req_start_hour,
   input  logic [5:0]  req_start_minute,
   input  logic [5:0]  req_start_second,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_base_seed,
   output logic        rsp_forward,
   output logic [5:0]  rsp_elapsed_days,
   output logic [4:0]  rsp_elapsed_hours,
   output logic [5:0]  rsp_elapsed_minutes,
   output logic [5:0]  rsp_elapsed_seconds,
   output logic [11:0] rsp_end_year,
   output logic [3:0]  rsp_end_month,
   output logic [4:0]  rsp_end_day,
   output logic [4:0]  rsp_end_hour,
   output logic [5:0]  rsp_end_minute,
   output logic [5:0]  rsp_end_second
);
   import sdrtc_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_BASE = 5'b00010,
      S_NEW  = 5'b00100,
      S_DIST = 5'b01000,
      S_STEP = 5'b10000
   } state_type;

   typedef struct packed {
      logic [31:0]  base_seed;
      logic         forward;
      logic [5:0]   days;
      logic [4:0]   hours;
      logic [5:0]   minutes;
      logic [5:0]   seconds;
      cal_time_type cal;
   } rsp_type;

   state_type    state_ff, state_in;
   logic [31:0]  init_ff, save_ff, nsave_ff, target_ff;
   logic [31:0]  base_ff, base_in;
   logic [31:0]  new_ff, new_in;
   logic         fwd_ff, fwd_in;
   logic [31:0]  remaining_ff, remaining_in;
   logic [5:0]   cnt_day_ff, cnt_day_in;
   logic [4:0]   cnt_hour_ff, cnt_hour_in;
   logic [5:0]   cnt_min_ff, cnt_min_in;
   logic [5:0]   cnt_sec_ff, cnt_sec_in;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         accept;
   logic         step_ok;
   logic         emit;
   logic [32:0]  sub_unit;
   cal_ctrl_type cal_ctrl;
   cal_time_type cal_start;
   cal_time_type cal_now;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   // one compare-subtract per cycle: borrow clear means a whole 1000 is left
   assign sub_unit = {1'b0, remaining_ff} - {1'b0, STEP_UNIT};
   assign step_ok  = !sub_unit[32];
   assign emit     = (state_ff == S_STEP) && !step_ok && (!rsp_valid_ff || rsp_ready);

   assign cal_start = '{year: req_start_year, month: req_start_month, day: req_start_day,
                        hour: req_start_hour, minute: req_start_minute,
                        second: req_start_second};

   assign cal_ctrl.load  = accept;
   assign cal_ctrl.clamp = (state_ff == S_NEW);
   assign cal_ctrl.step  = (state_ff == S_STEP) && step_ok;
   assign cal_ctrl.fwd   = fwd_ff;

   sdrtc_calendar u_calendar (
      .clock (clock),
      .reset (reset),
      .ctrl  (cal_ctrl),
      .start (cal_start),
      .now   (cal_now)
   );

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      new_in       = new_ff;
      fwd_in       = fwd_ff;
      remaining_in = remaining_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            base_in  = init_ff - save_ff;
            state_in = S_NEW;
         end
         S_NEW: begin
            new_in   = base_ff + nsave_ff;
            state_in = S_DIST;
         end
         S_DIST: begin
            fwd_in       = (target_ff > new_ff);
            remaining_in = (target_ff > new_ff) ? (target_ff - new_ff) : (new_ff - target_ff);
            state_in     = S_STEP;
         end
         S_STEP: begin
            if (step_ok) begin
               remaining_in = sub_unit[31:0];
            end else if (emit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // elapsed count runs up alongside the calendar
   always_comb begin
      cnt_day_in  = cnt_day_ff;
      cnt_hour_in = cnt_hour_ff;
      cnt_min_in  = cnt_min_ff;
      cnt_sec_in  = cnt_sec_ff;
      if (accept) begin
         cnt_day_in  = '0;
         cnt_hour_in = '0;
         cnt_min_in  = '0;
         cnt_sec_in  = '0;
      end else if (cal_ctrl.step) begin
         if (cnt_sec_ff == 6'd59) begin
            cnt_sec_in = '0;
            if (cnt_min_ff == 6'd59) begin
               cnt_min_in = '0;
               if (cnt_hour_ff == 5'd23) begin
                  cnt_hour_in = '0;
                  cnt_day_in  = cnt_day_ff + 6'd1;
               end else begin
                  cnt_hour_in = cnt_hour_ff + 5'd1;
               end
            end else begin
               cnt_min_in = cnt_min_ff + 6'd1;
            end
         end else begin
            cnt_sec_in = cnt_sec_ff + 6'd1;
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.base_seed  = base_ff;
         rsp_in.forward    = fwd_ff;
         rsp_in.days       = cnt_day_ff;
         rsp_in.hours      = cnt_hour_ff;
         rsp_in.minutes    = cnt_min_ff;
         rsp_in.seconds    = cnt_sec_ff;
         rsp_in.cal        = cal_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         remaining_ff <= '0;
         cnt_day_ff   <= '0;
         cnt_hour_ff  <= '0;
         cnt_min_ff   <= '0;
         cnt_sec_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         cnt_day_ff   <= cnt_day_in;
         cnt_hour_ff  <= cnt_hour_in;
         cnt_min_ff   <= cnt_min_in;
         cnt_sec_ff   <= cnt_sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         init_ff   <= req_initial_seed;
         save_ff   <= req_save_param;
         nsave_ff  <= req_new_save_param;
         target_ff <= req_target_seed;
      end
      base_ff <= base_in;
      new_ff  <= new_in;
      fwd_ff  <= fwd_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_base_seed       = rsp_ff.base_seed;
   assign rsp_forward         = rsp_ff.forward;
   assign rsp_elapsed_days    = rsp_ff.days;
   assign rsp_elapsed_hours   = rsp_ff.hours;
   assign rsp_elapsed_minutes = rsp_ff.minutes;
   assign rsp_elapsed_seconds = rsp_ff.seconds;
   assign rsp_end_year        = rsp_ff.cal.year;
   assign rsp_end_month       = rsp_ff.cal.month;
   assign rsp_end_day         = rsp_ff.cal.day;
   assign rsp_end_hour        = rsp_ff.cal.hour;
   assign rsp_end_minute      = rsp_ff.cal.minute;
   assign rsp_end_second      = rsp_ff.cal.second;

   `SDRTC_ASSERT(a_step_sub, clock, reset, (state_ff == S_STEP && step_ok) |=> (remaining_ff == $past(remaining_ff) - STEP_UNIT), "remaining distance did not drop by one unit")
   `SDRTC_ASSERT(a_accept_clear, clock, reset, accept |=> (state_ff == S_BASE && cnt_sec_ff == 6'd0 && cnt_day_ff == 6'd0), "elapsed count not cleared on a new item")
   `SDRTC_ASSERT(a_cnt_range, clock, reset, (cnt_sec_ff <= 6'd59 && cnt_min_ff <= 6'd59 && cnt_hour_ff <= 5'd23), "elapsed count field out of range")

endmodule
